[sv/sphd_pkg.sv]
package sphd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int INDEX_WIDTH  = 20;
	localparam int THR_WIDTH    = 16;
	localparam int CFG_INDEX_W  = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [SAMPLE_WIDTH+1:0] acc_t;
	typedef logic [INDEX_WIDTH-1:0]         index_t;
	typedef logic signed [THR_WIDTH-1:0]    thr_t;

	localparam index_t INDEX_MAX = {INDEX_WIDTH{1'b1}};

	localparam thr_t HIGH_THRESHOLD_RST = THR_WIDTH'(2511);
	localparam thr_t LOW_THRESHOLD_RST  = THR_WIDTH'(1280);

	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = CFG_INDEX_W'(1);

	typedef struct packed {
		sample_t smoothed;
		index_t  sample_index;
		logic    alarm_raised;
		logic    alarm_active;
		sample_t peak_value;
		index_t  peak_index;
		logic    last_result;
	} result_t;

	typedef struct packed {
		logic    alarm;
		sample_t peak;
		index_t  peak_at;
		index_t  idx;
	} run_t;

	typedef struct packed {
		result_t res;
		run_t    nxt;
	} emit_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} fifo_push_t;

	// floor(sum / 4)
	function automatic sample_t quarter(acc_t sum);
		acc_t tmp;
		tmp = sum >>> 2;
		return tmp[SAMPLE_WIDTH-1:0];
	endfunction

	function automatic emit_t emit(sample_t v, logic last, run_t run, thr_t hi, thr_t lo);
		emit_t e;
		e.nxt = run;
		e.res.alarm_raised = 1'b0;
		if (v > hi && !run.alarm) begin
			e.res.alarm_raised = 1'b1;
			e.nxt.alarm = 1'b1;
		end else if (v < lo && run.alarm) begin
			e.nxt.alarm = 1'b0;
		end
		if (run.idx == '0) begin
			e.nxt.peak    = v;
			e.nxt.peak_at = '0;
		end else if (v > run.peak) begin
			e.nxt.peak    = v;
			e.nxt.peak_at = run.idx;
		end
		if (run.idx != INDEX_MAX) begin
			e.nxt.idx = run.idx + INDEX_WIDTH'(1);
		end
		e.res.smoothed     = v;
		e.res.sample_index = run.idx;
		e.res.alarm_active = e.nxt.alarm;
		e.res.peak_value   = e.nxt.peak;
		e.res.peak_index   = e.nxt.peak_at;
		e.res.last_result  = last;
		return e;
	endfunction

endpackage

[sv/sphd_ifs.sv]
interface sphd_sample_if import sphd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    last_sample;

	modport source(output valid, output sample, output last_sample, input ready);
	modport sink(input valid, input sample, input last_sample, output ready);
endinterface

interface sphd_result_if import sphd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t smoothed;
	index_t  sample_index;
	logic    alarm_raised;
	logic    alarm_active;
	sample_t peak_value;
	index_t  peak_index;
	logic    last_result;

	modport source(output valid, output smoothed, output sample_index, output alarm_raised,
		output alarm_active, output peak_value, output peak_index, output last_result,
		input ready);
	modport sink(input valid, input smoothed, input sample_index, input alarm_raised,
		input alarm_active, input peak_value, input peak_index, input last_result,
		output ready);
endinterface

[sv/sphd_result_fifo.sv]
module sphd_result_fifo import sphd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fifo_push_t           push,
	output logic                 space_ok,
	sphd_result_if.source        results
);

	result_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  pop;
	result_t               head;

	assign pop      = results.valid && results.ready;
	assign space_ok = count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2);
	assign head     = mem_q[rd_ptr_q];

	assign results.valid        = count_q != '0;
	assign results.smoothed     = head.smoothed;
	assign results.sample_index = head.sample_index;
	assign results.alarm_raised = head.alarm_raised;
	assign results.alarm_active = head.alarm_active;
	assign results.peak_value   = head.peak_value;
	assign results.peak_index   = head.peak_index;
	assign results.last_result  = head.last_result;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + (FIFO_PTR_W+1)'(push.cnt) - (FIFO_PTR_W+1)'(pop);
		end
	end

endmodule

[sv/smooth_peak_hysteresis_detector.sv]
// channel  | dir | handshake    | payload
// samples  | in  | valid/ready  | sample, last_sample
// results  | out | valid/ready  | smoothed, sample_index, alarm_raised, alarm_active,
//          |     |              | peak_value, peak_index, last_result
// config   | in  | wr_en        | wr_index, wr_data
//
// One item per cycle while ready is high. Results are computed in the accept cycle
// and land in a four-entry result queue in the next cycle; a final sample pushes
// two results unless it starts its run. Input ready is high while the queue has
// room for two results. Reset clears the run state and queue and loads the
// default thresholds. A stalled output fills the queue and then holds samples off.
module smooth_peak_hysteresis_detector import sphd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [THR_WIDTH-1:0]   wr_data,
	sphd_sample_if.sink            samples,
	sphd_result_if.source          results
);

	thr_t       high_q;
	thr_t       low_q;
	sample_t    older_q;
	sample_t    newer_q;
	logic [1:0] raw_count_q;
	run_t       run_q;

	logic       accept;
	logic       space_ok;
	sample_t    s;
	sample_t    v0;
	sample_t    v1;
	emit_t      e0;
	emit_t      e1;
	fifo_push_t push;

	assign samples.ready = space_ok;
	assign accept        = samples.valid && space_ok;
	assign s             = samples.sample;

	always_comb begin
		case (raw_count_q)
			2'd0:    v0 = s;
			2'd1:    v0 = quarter(acc_t'(newer_q) + acc_t'(newer_q) + acc_t'(newer_q)
				+ acc_t'(s));
			default: v0 = quarter(acc_t'(older_q) + (acc_t'(newer_q) <<< 1) + acc_t'(s));
		endcase
		v1 = quarter(acc_t'(newer_q) + acc_t'(s) + acc_t'(s) + acc_t'(s));
		e0 = emit(v0, raw_count_q == 2'd0, run_q, high_q, low_q);
		e1 = emit(v1, 1'b1, e0.nxt, high_q, low_q);

		push.first  = e0.res;
		push.second = e1.res;
		push.cnt    = 2'd0;
		if (accept) begin
			if (raw_count_q == 2'd0) begin
				push.cnt = samples.last_sample ? 2'd1 : 2'd0;
			end else begin
				push.cnt = samples.last_sample ? 2'd2 : 2'd1;
			end
		end
	end

	sphd_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.results  (results)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q      <= HIGH_THRESHOLD_RST;
			low_q       <= LOW_THRESHOLD_RST;
			older_q     <= '0;
			newer_q     <= '0;
			raw_count_q <= 2'd0;
			run_q       <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_HIGH_THRESHOLD: high_q <= thr_t'(wr_data);
					REG_LOW_THRESHOLD:  low_q  <= thr_t'(wr_data);
					default: ;
				endcase
			end
			if (accept) begin
				if (samples.last_sample) begin
					older_q     <= '0;
					newer_q     <= '0;
					raw_count_q <= 2'd0;
					run_q       <= '0;
				end else if (raw_count_q == 2'd0) begin
					newer_q     <= s;
					raw_count_q <= 2'd1;
				end else begin
					older_q     <= newer_q;
					newer_q     <= s;
					raw_count_q <= 2'd2;
					run_q       <= e0.nxt;
				end
			end
		end
	end

endmodule
